### rtl/gwt_pkg.sv
// Package for the G-code word tokenizer: result codes, character constants,
// field widths and the default digit limit.
// No dependencies.
package gwt_pkg;

   // Result kinds carried on rsp_tuser
   typedef enum logic [2:0] {
      KIND_WORD       = 3'd0,
      KIND_WORD_END   = 3'd1,
      KIND_LINE_END   = 3'd2,
      KIND_BAD_LETTER = 3'd3,
      KIND_BAD_NUMBER = 3'd4
   } kind_type;

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_LETTER = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_NUM    = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned LETTER_W   = 5;
   localparam int unsigned MANT_W     = 30;
   localparam int unsigned EXP_W      = 6;
   localparam int unsigned RSP_DATA_W = 48;  // 42 field bits padded to whole bytes

   localparam int unsigned MAX_DIGITS_DEFAULT = 8;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CH_UPA   = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UPZ   = 8'd90;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;

   localparam logic signed [EXP_W-1:0] EXP_MAX = 6'sd31;

endpackage

### rtl/gcode_word_tokenizer_core.sv
// G-code word tokenizer: splits a byte stream of command lines into words
// (letter, sign, mantissa, decimal exponent). Depends on gwt_pkg.
//
// Channel   Dir  Payload                                        Transfer when
// req_*     in   tdata[7:0] char_in                             req_tvalid & req_tready
// rsp_*     out  tuser[2:0] kind; tdata letter/neg/mant/exp     rsp_tvalid & rsp_tready
//
// A transfer lands in an input register; when the result register is free, the
// parser state and, where a word or an error finishes, the result register
// are updated from it.
// The input register refills while its byte is being parsed, so throughput is
// one byte per cycle whenever the result register is free or being drained.
// A stalled result holds the parser and, through the input register, req_tready.
// Reset (synchronous, active high) returns the parser to expecting a letter.
module gcode_word_tokenizer_core #(
   parameter int unsigned MAX_DIGITS = gwt_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gwt_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] char_in
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gwt_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [4:0] word_letter, [5] is_negative,
                                                         // [35:6] mantissa,
                                                         // [41:36] dec_exponent, [47:42] zero
   output logic [2:0]                       rsp_tuser    // [2:0] kind
);

   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

   // input register
   logic                          in_valid_ff;
   logic [gwt_pkg::CHAR_W-1:0]    char_ff;

   // parser state
   gwt_pkg::phase_type            phase_ff, phase_in;
   logic [gwt_pkg::LETTER_W-1:0]  letter_ff, letter_in;
   logic                          neg_ff, neg_in;
   logic                          point_ff, point_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [gwt_pkg::MANT_W-1:0]    mant_ff, mant_in;
   logic signed [gwt_pkg::EXP_W-1:0] exp_ff, exp_in;

   // result register
   logic                          rsp_valid_ff;
   gwt_pkg::kind_type             kind_ff, kind_in;
   logic [gwt_pkg::RSP_DATA_W-1:0] data_ff, data_in;

   logic emit;
   logic with_word;
   logic out_free;
   logic process_go;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign process_go = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || process_go;

   always_comb begin
      logic is_digit;
      logic sign_taken;
      logic [3:0] digit;

      is_digit   = (char_ff >= gwt_pkg::CH_ZERO) && (char_ff <= gwt_pkg::CH_NINE);
      sign_taken = 1'b0;
      digit      = char_ff[3:0];

      phase_in  = phase_ff;
      letter_in = letter_ff;
      neg_in    = neg_ff;
      point_in  = point_ff;
      count_in  = count_ff;
      mant_in   = mant_ff;
      exp_in    = exp_ff;
      emit      = 1'b0;
      with_word = 1'b0;
      kind_in   = gwt_pkg::KIND_WORD;

      case (phase_ff)
         gwt_pkg::PH_SKIP: begin
            if (char_ff == gwt_pkg::CH_NUL) begin
               phase_in = gwt_pkg::PH_LETTER;
            end
         end
         gwt_pkg::PH_LETTER: begin
            if (char_ff == gwt_pkg::CH_NUL || char_ff == gwt_pkg::CH_ZERO ||
                char_ff == gwt_pkg::CH_SPACE) begin
               emit     = 1'b1;
               kind_in  = gwt_pkg::KIND_LINE_END;
               phase_in = (char_ff == gwt_pkg::CH_NUL) ? gwt_pkg::PH_LETTER
                                                       : gwt_pkg::PH_SKIP;
            end else if (char_ff < gwt_pkg::CH_UPA || char_ff > gwt_pkg::CH_UPZ) begin
               emit     = 1'b1;
               kind_in  = gwt_pkg::KIND_BAD_LETTER;
               phase_in = gwt_pkg::PH_SKIP;
            end else begin
               letter_in = gwt_pkg::LETTER_W'(char_ff - gwt_pkg::CH_UPA);
               neg_in    = 1'b0;
               point_in  = 1'b0;
               count_in  = '0;
               mant_in   = '0;
               exp_in    = '0;
               phase_in  = gwt_pkg::PH_SIGN;
            end
         end
         gwt_pkg::PH_SIGN, gwt_pkg::PH_NUM: begin
            if (phase_ff == gwt_pkg::PH_SIGN) begin
               phase_in = gwt_pkg::PH_NUM;
               if (char_ff == gwt_pkg::CH_MINUS) begin
                  neg_in     = 1'b1;
                  sign_taken = 1'b1;
               end else if (char_ff == gwt_pkg::CH_PLUS) begin
                  sign_taken = 1'b1;
               end
            end
            if (!sign_taken) begin
               if (is_digit) begin
                  if (count_ff < CNT_MAX) begin
                     count_in = count_ff + CNT_W'(1);
                     if (point_ff) begin
                        exp_in = exp_ff - gwt_pkg::EXP_W'(1);
                     end
                     mant_in = (mant_ff << 3) + (mant_ff << 1)
                             + gwt_pkg::MANT_W'(digit);
                  end else if (!point_ff && exp_ff != gwt_pkg::EXP_MAX) begin
                     // drop the digit, scale up instead
                     exp_in = exp_ff + gwt_pkg::EXP_W'(1);
                  end
               end else if (char_ff == gwt_pkg::CH_POINT && !point_ff) begin
                  point_in = 1'b1;
               end else if (count_ff == '0) begin
                  // separator before any digit
                  emit     = 1'b1;
                  kind_in  = gwt_pkg::KIND_BAD_NUMBER;
                  phase_in = (char_ff == gwt_pkg::CH_NUL) ? gwt_pkg::PH_LETTER
                                                          : gwt_pkg::PH_SKIP;
               end else begin
                  emit      = 1'b1;
                  with_word = 1'b1;
                  kind_in   = (char_ff == gwt_pkg::CH_NUL) ? gwt_pkg::KIND_WORD_END
                                                           : gwt_pkg::KIND_WORD;
                  phase_in  = gwt_pkg::PH_LETTER;
               end
            end
         end
         default: begin
            phase_in = gwt_pkg::PH_LETTER;
         end
      endcase

      if (with_word) begin
         data_in = {6'd0, exp_ff, mant_ff, neg_ff, letter_ff};
      end else begin
         data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         char_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= gwt_pkg::PH_LETTER;
         letter_ff <= '0;
         neg_ff    <= 1'b0;
         point_ff  <= 1'b0;
         count_ff  <= '0;
         mant_ff   <= '0;
         exp_ff    <= '0;
      end else if (process_go) begin
         phase_ff  <= phase_in;
         letter_ff <= letter_in;
         neg_ff    <= neg_in;
         point_ff  <= point_in;
         count_ff  <= count_in;
         mant_ff   <= mant_in;
         exp_ff    <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (process_go && emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

   // error and line-end results carry no word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == gwt_pkg::KIND_LINE_END ||
                       kind_ff == gwt_pkg::KIND_BAD_LETTER ||
                       kind_ff == gwt_pkg::KIND_BAD_NUMBER) |-> data_ff == '0)
      else $error("error result carries word data");

   // an unparsed byte waits while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(char_ff))
      else $error("pending byte lost under stall");

   // exponent never drops below the fractional digit limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $signed(data_ff[41:36]) >= -$signed(gwt_pkg::EXP_W'(MAX_DIGITS)))
      else $error("exponent out of range");

endmodule

### verif/tb.sv
// Testbench for gcode_word_tokenizer_core: drives command-line bytes over the
// req_ stream, predicts each token in a small scoreboard class and checks the rsp_ stream.
// Depends on gwt_pkg and the tokenizer RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIVE_TARGET = 1200;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned HOLD_START  = 500;
   localparam int unsigned HOLD_CYCLES = 400;

   typedef struct {
      gwt_pkg::kind_type                 kind;
      logic [gwt_pkg::LETTER_W-1:0]      letter;
      logic                              neg;
      logic [gwt_pkg::MANT_W-1:0]        mant;
      logic signed [gwt_pkg::EXP_W-1:0]  expo;
   } token_type;

   class scoreboard_type;
      gwt_pkg::phase_type           phase;
      logic [gwt_pkg::LETTER_W-1:0] letter;
      logic                         neg;
      logic                         point;
      int unsigned                  ndigits;
      logic [gwt_pkg::MANT_W-1:0]   mant;
      int                           expo;
      token_type                    tokens[$];
      int unsigned                  mismatches;
      int unsigned                  kind_count[5];
      int unsigned                  saturated;

      function new();
         phase = gwt_pkg::PH_LETTER;
         letter = '0;
         neg = 1'b0;
         point = 1'b0;
         ndigits = 0;
         mant = '0;
         expo = 0;
         mismatches = 0;
         saturated = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void push_token(gwt_pkg::kind_type kind, bit with_word);
         token_type t;
         t.kind = kind;
         t.letter = with_word ? letter : '0;
         t.neg = with_word ? neg : 1'b0;
         t.mant = with_word ? mant : '0;
         t.expo = with_word ? gwt_pkg::EXP_W'(expo) : '0;
         if (with_word && expo == int'(gwt_pkg::EXP_MAX)) saturated++;
         tokens.push_back(t);
      endfunction

      // Advance the parser by one accepted byte; returns 0 when the byte was skipped.
      function bit note_char(logic [gwt_pkg::CHAR_W-1:0] ch);
         if (phase == gwt_pkg::PH_SKIP) begin
            if (ch == gwt_pkg::CH_NUL) phase = gwt_pkg::PH_LETTER;
            return 1'b0;
         end
         if (phase == gwt_pkg::PH_LETTER) begin
            if (ch == gwt_pkg::CH_NUL || ch == gwt_pkg::CH_ZERO || ch == gwt_pkg::CH_SPACE) begin
               phase = (ch == gwt_pkg::CH_NUL) ? gwt_pkg::PH_LETTER : gwt_pkg::PH_SKIP;
               push_token(gwt_pkg::KIND_LINE_END, 1'b0);
            end else if (ch < gwt_pkg::CH_UPA || ch > gwt_pkg::CH_UPZ) begin
               phase = gwt_pkg::PH_SKIP;
               push_token(gwt_pkg::KIND_BAD_LETTER, 1'b0);
            end else begin
               letter = gwt_pkg::LETTER_W'(ch - gwt_pkg::CH_UPA);
               neg = 1'b0;
               point = 1'b0;
               ndigits = 0;
               mant = '0;
               expo = 0;
               phase = gwt_pkg::PH_SIGN;
            end
            return 1'b1;
         end
         // a sign only counts directly after the letter
         if (phase == gwt_pkg::PH_SIGN && (ch == gwt_pkg::CH_MINUS || ch == gwt_pkg::CH_PLUS)) begin
            neg = (ch == gwt_pkg::CH_MINUS);
            phase = gwt_pkg::PH_NUM;
            return 1'b1;
         end
         phase = gwt_pkg::PH_NUM;
         if (ch >= gwt_pkg::CH_ZERO && ch <= gwt_pkg::CH_NINE) begin
            if (ndigits < gwt_pkg::MAX_DIGITS_DEFAULT) begin
               ndigits++;
               if (point) expo--;
               mant = gwt_pkg::MANT_W'(mant * 10 + (ch - gwt_pkg::CH_ZERO));
            end else if (!point && expo < int'(gwt_pkg::EXP_MAX)) begin
               expo++;
            end
         end else if (ch == gwt_pkg::CH_POINT && !point) begin
            point = 1'b1;
         end else if (ndigits == 0) begin
            phase = (ch == gwt_pkg::CH_NUL) ? gwt_pkg::PH_LETTER : gwt_pkg::PH_SKIP;
            push_token(gwt_pkg::KIND_BAD_NUMBER, 1'b0);
         end else begin
            phase = gwt_pkg::PH_LETTER;
            push_token((ch == gwt_pkg::CH_NUL) ? gwt_pkg::KIND_WORD_END : gwt_pkg::KIND_WORD,
                       1'b1);
         end
         return 1'b1;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH %0d: %s", mismatches, what);
      endfunction

      function void check_token(logic [2:0] kind, logic [gwt_pkg::RSP_DATA_W-1:0] data);
         token_type want;
         if (tokens.size() == 0) begin
            flag($sformatf("token kind %0d data %h arrived with none pending", kind, data));
            return;
         end
         want = tokens.pop_front();
         kind_count[int'(want.kind)]++;
         if (kind !== want.kind || data[4:0] !== want.letter || data[5] !== want.neg
               || data[35:6] !== want.mant || data[41:36] !== want.expo
               || data[47:42] !== '0)
            flag($sformatf({"want kind %0d letter %0d neg %0b mant %0d exp %0d; ",
                            "got kind %0d letter %0d neg %0b mant %0d exp %0d pad %h"},
                           want.kind, want.letter, want.neg, want.mant, want.expo,
                           kind, data[4:0], data[5], data[35:6], $signed(data[41:36]),
                           data[47:42]));
      endfunction

      function int unsigned pending();
         return tokens.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [gwt_pkg::CHAR_W-1:0]     req_tdata;    // [7:0] char_in
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [gwt_pkg::RSP_DATA_W-1:0] rsp_tdata;    // [4:0] letter, [5] neg, [35:6] mantissa,
                                                 // [41:36] exponent, [47:42] zero
   logic [2:0]                     rsp_tuser;    // [2:0] kind

   scoreboard_type sb = new();
   logic [gwt_pkg::CHAR_W-1:0] line_chars[$];
   int unsigned chars_sent = 0;
   int unsigned chars_live = 0;
   int unsigned tokens_taken = 0;
   int unsigned cycles = 0;

   gcode_word_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d tokens pending", cycles, sb.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_token(rsp_tuser, rsp_tdata);
         tokens_taken <= tokens_taken + 1;
      end
   end

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
   endfunction

   // Mostly well-formed lines with random content, some noise and broken words.
   function void make_line();
      int unsigned sel;
      int unsigned nwords;
      int unsigned ndig;
      int unsigned pt;
      bit          with_point;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         repeat ($urandom_range(1, 10))
            line_chars.push_back(gwt_pkg::CHAR_W'($urandom_range(0, 255)));
         line_chars.push_back(gwt_pkg::CH_NUL);
         return;
      end
      if (sel < 15) begin
         line_chars.push_back(gwt_pkg::CH_NUL);
         return;
      end
      nwords = $urandom_range(1, 5);
      for (int w = 0; w < nwords; w++) begin
         line_chars.push_back(gwt_pkg::CH_UPA + gwt_pkg::CHAR_W'($urandom_range(0, 25)));
         sel = $urandom_range(0, 5);
         if (sel == 0) line_chars.push_back(gwt_pkg::CH_MINUS);
         else if (sel == 1) line_chars.push_back(gwt_pkg::CH_PLUS);
         sel = $urandom_range(0, 99);
         if (sel < 4) ndig = 0;
         else if (sel < 12) ndig = $urandom_range(7, 12);
         else if (sel < 15) ndig = $urandom_range(36, 45);
         else ndig = $urandom_range(1, 6);
         with_point = 1'($urandom_range(0, 1));
         pt = $urandom_range(0, ndig);
         for (int i = 0; i <= ndig; i++) begin
            if (with_point && i == pt) line_chars.push_back(gwt_pkg::CH_POINT);
            if (i < ndig)
               line_chars.push_back(gwt_pkg::CH_ZERO + gwt_pkg::CHAR_W'($urandom_range(0, 9)));
         end
         sel = $urandom_range(0, 99);
         if (w == nwords - 1) begin
            if (sel < 65) begin
               line_chars.push_back(gwt_pkg::CH_NUL);
            end else begin
               line_chars.push_back((sel < 85) ? gwt_pkg::CH_SPACE
                                               : gwt_pkg::CHAR_W'($urandom_range(1, 255)));
               if (sel % 2 == 0) line_chars.push_back(gwt_pkg::CH_ZERO);
               repeat ($urandom_range(0, 3))
                  line_chars.push_back(gwt_pkg::CHAR_W'($urandom_range(1, 255)));
               line_chars.push_back(gwt_pkg::CH_NUL);
            end
         end else if (sel < 80) begin
            line_chars.push_back(gwt_pkg::CH_SPACE);
         end else if (sel < 90) begin
            // letters run together: the next letter is eaten as the separator
         end else begin
            line_chars.push_back(gwt_pkg::CHAR_W'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic send_line();
      int unsigned gap;
      logic [gwt_pkg::CHAR_W-1:0] ch;
      while (line_chars.size() != 0) begin
         ch = line_chars.pop_front();
         gap = ((chars_sent % 150) < 30) ? 0 : $urandom_range(0, 13);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= ch;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (sb.note_char(ch)) chars_live++;
         chars_sent++;
      end
   endtask

   // Receiver: random stalls per token, plus one long hold-off to back the block up.
   initial begin
      int unsigned stall;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && chars_sent >= HOLD_START) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = ((tokens_taken % 60) < 12) ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: bare line end, signed word ended by NUL, plus sign, second point,
      // empty number, bad letter with skipped tail, zero line end, sign after sign
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("Z-1.5");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("A+7 ");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("G.5.");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("X");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("ax");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("0");
      line_chars.push_back(gwt_pkg::CH_NUL);
      add_text("M+-");
      line_chars.push_back(gwt_pkg::CH_NUL);
      send_line();

      chars_live = 0;
      while (chars_live < LIVE_TARGET) begin
         make_line();
         send_line();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes; checked %0d words, %0d words at line end, %0d line ends,",
               chars_sent, sb.kind_count[0], sb.kind_count[1], sb.kind_count[2]);
      $display("%0d bad letters, %0d bad numbers, %0d words with a saturated exponent.",
               sb.kind_count[3], sb.kind_count[4], sb.saturated);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total", sb.mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
rtl/gwt_pkg.sv
rtl/gcode_word_tokenizer_core.sv
verif/tb.sv
